// ----- hdl/mvr_pkg.sv -----
// Package for the 3x3 majority-vote row filter.
// Holds the item structs, the per-column control struct and the sequencer states.
// Depends on nothing; every other file in this block imports it.
`timescale 1ns / 1ps

package mvr_pkg;

  localparam int MVR_ROW_W = 64;
  localparam int MVR_COLS_W = 7;
  localparam logic [MVR_COLS_W-1:0] MVR_COLS_RESET = 7'd64;

  typedef struct packed {
    logic [MVR_ROW_W-1:0] row_bits;
    logic                 last_row;
  } in_item_t;

  typedef struct packed {
    logic [MVR_ROW_W-1:0] new_row_bits;
    logic                 is_last;
  } out_item_t;

  // Control shared by every column cell in one cycle.
  typedef struct packed {
    logic up_ok;       // row above the middle row is inside the grid
    logic down_ok;     // row below the middle row is inside the grid
    logic mid_from_in; // middle row is the incoming row (single-row grid)
    logic load_top;    // start a grid: above <= 0, center <= incoming
    logic shift;       // above <= center, center <= incoming
    logic clear;       // drop the held rows
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_EMPTY,
    ST_TOP,
    ST_FULL,
    ST_FLUSH
  } mvr_state_t;

endpackage

// ----- hdl/mvr_cell.sv -----
// One column cell of the majority-vote row filter.
// Holds the column's above and center bits and votes over its 3x3 window.
// Depends on mvr_pkg.
`timescale 1ns / 1ps

module mvr_cell (
  input  logic              clk,
  input  mvr_pkg::cell_ctl_t ctl,
  input  logic              in_bit,
  input  logic              active,
  input  logic              left_ok,
  input  logic              right_ok,
  input  logic [1:0]        left_ones,
  input  logic [1:0]        right_ones,
  output logic [1:0]        col_ones,
  output logic              new_bit
);
  import mvr_pkg::*;

  logic       above_r;
  logic       center_r;
  logic       up_bit;
  logic       mid_bit;
  logic       down_bit;
  logic [3:0] ones;
  logic [1:0] nrows;
  logic [1:0] width;
  logic [3:0] cells;
  logic [4:0] twice;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      above_r  <= 1'b0;
      center_r <= 1'b0;
    end else if (ctl.load_top) begin
      above_r  <= 1'b0;
      center_r <= in_bit;
    end else if (ctl.shift) begin
      above_r  <= center_r;
      center_r <= in_bit;
    end
  end

  always_comb begin
    up_bit   = above_r & ctl.up_ok;
    mid_bit  = ctl.mid_from_in ? in_bit : center_r;
    down_bit = in_bit & ctl.down_ok;
    col_ones = 2'({1'b0, up_bit} + {1'b0, mid_bit} + {1'b0, down_bit});

    ones  = {2'b00, col_ones}
          + (left_ok  ? {2'b00, left_ones}  : 4'd0)
          + (right_ok ? {2'b00, right_ones} : 4'd0);
    nrows = 2'd1 + {1'b0, ctl.up_ok} + {1'b0, ctl.down_ok};
    width = 2'd1 + {1'b0, left_ok} + {1'b0, right_ok};
    cells = {2'b00, nrows} * {2'b00, width};
    twice = {ones, 1'b0};

    if (!active) begin
      new_bit = 1'b0;
    end else if (twice > {1'b0, cells}) begin
      new_bit = 1'b1;
    end else if (twice == {1'b0, cells}) begin
      new_bit = mid_bit;
    end else begin
      new_bit = 1'b0;
    end
  end

endmodule

// ----- hdl/mvr_outbuf.sv -----
// Output register with a skid stage for the majority-vote row filter.
// Holds up to two finished items so the input side keeps moving under stall.
// Depends on mvr_pkg.
`timescale 1ns / 1ps

module mvr_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mvr_pkg::out_item_t  push_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mvr_pkg::out_item_t  out_data,
  output logic                full
);
  import mvr_pkg::*;

  logic      main_valid_r, main_valid_nxt;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t main_data_r, main_data_nxt;
  out_item_t skid_data_r, skid_data_nxt;
  logic      pop;

  assign pop = main_valid_r && !out_stall;

  // A push only happens while the skid stage is empty.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        main_data_nxt = push_data;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end else begin
        main_data_nxt  = push_data;
        main_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;
  assign full      = skid_valid_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds an item while the output register is empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("item pushed while both output stages are occupied");

endmodule

// ----- hdl/majority_vote_3x3_row_step.sv -----
// A row's result is pushed into the output buffer when the row below it is accepted, and a
// one-row grid's result when its row is accepted. A bottom row's result is pushed from the
// flush state, after the result of the row above it, once the skid stage is not full.
// Throughput: one row per cycle unless the skid stage is full; input stalls in the flush
// state, while the bottom row is voted from the held rows (column cells vote once per cycle).
// Reset (synchronous, rst_n low): no rows held, output empty, column count 64.
`timescale 1ns / 1ps

module majority_vote_3x3_row_step #(
  parameter int ROW_BITS = mvr_pkg::MVR_ROW_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mvr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mvr_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [mvr_pkg::MVR_COLS_W-1:0]      cfg_wdata
);
  import mvr_pkg::*;

  // The grid is held as a row of column cells. Each cell keeps the bit of the
  // row above and of the center row for its own column and passes its column
  // vote count to both neighbors every cycle, so a whole row is voted at once.
  localparam logic [MVR_COLS_W-1:0] MAX_COLS = MVR_COLS_W'(ROW_BITS);

  mvr_state_t                state_r, state_nxt;
  logic [MVR_COLS_W-1:0]     cols_r;
  logic [MVR_COLS_W-1:0]     cols_eff;
  logic [ROW_BITS-1:0]       active;
  logic [ROW_BITS-1:0][1:0]  col_ones;
  logic [MVR_ROW_W-1:0]      new_bits;
  cell_ctl_t                 ctl;
  logic                      accept;
  logic                      push;
  logic                      push_last;
  logic                      buf_full;
  out_item_t                 push_data;

  // Column count register; a zero acts as one column and anything beyond the
  // cell row acts as the full row.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= MVR_COLS_RESET;
    end else if (cfg_we) begin
      cols_r <= cfg_wdata;
    end
  end

  always_comb begin
    if (cols_r == '0) begin
      cols_eff = MVR_COLS_W'(1);
    end else if (cols_r > MAX_COLS) begin
      cols_eff = MAX_COLS;
    end else begin
      cols_eff = cols_r;
    end
    for (int j = 0; j < ROW_BITS; j++) begin
      active[j] = MVR_COLS_W'(j) < cols_eff;
    end
  end

  // Input is held back while the skid stage is full or while the bottom row
  // of a grid is being flushed.
  assign in_stall = buf_full || (state_r == ST_FLUSH);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer: decides which rows the cells vote over and how they update.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    push      = 1'b0;
    push_last = 1'b0;
    case (state_r)
      ST_EMPTY: begin
        if (accept) begin
          if (in_data.last_row) begin
            // A one-row grid: vote the incoming row alone and hold nothing.
            ctl.mid_from_in = 1'b1;
            ctl.clear       = 1'b1;
            push            = 1'b1;
            push_last       = 1'b1;
          end else begin
            ctl.load_top = 1'b1;
            state_nxt    = ST_TOP;
          end
        end
      end
      ST_TOP, ST_FULL: begin
        if (accept) begin
          // The center row has its lower neighbor now and leaves.
          ctl.up_ok   = (state_r == ST_FULL);
          ctl.down_ok = 1'b1;
          ctl.shift   = 1'b1;
          push        = 1'b1;
          state_nxt   = in_data.last_row ? ST_FLUSH : ST_FULL;
        end
      end
      ST_FLUSH: begin
        // The bottom row sits in the center with no row below it.
        if (!buf_full) begin
          ctl.up_ok = 1'b1;
          ctl.clear = 1'b1;
          push      = 1'b1;
          push_last = 1'b1;
          state_nxt = ST_EMPTY;
        end
      end
      default: begin
        state_nxt = ST_EMPTY;
      end
    endcase
  end

  // The cell row. Inactive columns neither vote nor count for their neighbors,
  // and the incoming bits there are dropped before they are stored.
  for (genvar j = 0; j < MVR_ROW_W; j++) begin : g_col
    if (j < ROW_BITS) begin : g_cell
      logic [1:0] left_ones;
      logic [1:0] right_ones;
      logic       right_ok;

      if (j > 0) begin : g_left
        assign left_ones = col_ones[j-1];
      end else begin : g_left_edge
        assign left_ones = 2'd0;
      end

      if (j < ROW_BITS - 1) begin : g_right
        assign right_ones = col_ones[j+1];
        assign right_ok   = active[j+1];
      end else begin : g_right_edge
        assign right_ones = 2'd0;
        assign right_ok   = 1'b0;
      end

      mvr_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .in_bit     (in_data.row_bits[j] & active[j]),
        .active     (active[j]),
        .left_ok    ((j > 0) ? 1'b1 : 1'b0),
        .right_ok   (right_ok),
        .left_ones  (left_ones),
        .right_ones (right_ones),
        .col_ones   (col_ones[j]),
        .new_bit    (new_bits[j])
      );
    end else begin : g_unused
      assign new_bits[j] = 1'b0;
    end
  end

  assign push_data.new_row_bits = new_bits;
  assign push_data.is_last      = push_last;

  mvr_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .full      (buf_full)
  );

  a_last_enters_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.last_row && (state_r == ST_TOP || state_r == ST_FULL))
      |=> (state_r == ST_FLUSH))
    else $error("bottom row with rows held did not start a flush");

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> in_stall)
    else $error("input accepted during a flush");

  a_result_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid)
    else $error("finished item did not reach the output register");

  a_top_row_holds_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMPTY && accept && !in_data.last_row) |-> !push)
    else $error("top row of a grid produced an item on its own");

endmodule
